// ----- rtl/swm_pkg.sv -----
package swm_pkg;

   // Width of the window size register on the configuration port.
   localparam int CSR_WIDTH = 7;

   // Broadcast from the controller to every cell of the sorted row.
   typedef struct packed {
      logic update;   // load the next value this cycle
      logic remove;   // window is full: the oldest sample leaves
   } swm_ctrl_type;

   // Per-cell compare results handed to both neighbors.
   typedef struct packed {
      logic in_range;   // cell holds a live entry
      logic below_old;  // live entry is below the leaving sample
      logic le_new;     // entry is at or below the arriving sample
   } swm_flag_type;

endpackage

// ----- rtl/sliding_window_median_top.sv -----
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_ready   req_sample, req_restart
// rsp      out        rsp_valid / rsp_ready   rsp_median_x2
// csr      in         csr_write_enable        csr_window_size
//
// A sample that fills or keeps the window full goes through accept, row update, middle
// pick and result load; a sample that only grows the window returns to idle after the
// row update. The arrival ring is read through a register, and the two middle cells of
// the sorted row are registered in the pick step ahead of the final add.
// Synchronous active-high reset empties the window and sets the window size to 1.
// A result waiting on rsp holds the block only at its result load step.
module sliding_window_median_top #(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_WIDTH-1:0]             req_sample,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [SAMPLE_WIDTH:0]               rsp_median_x2,
   input  logic                                csr_write_enable,
   input  logic [swm_pkg::CSR_WIDTH-1:0]       csr_window_size
);

   import swm_pkg::*;

   // CW holds a count up to WINDOW_MAX, PW indexes a ring slot or a cell.
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_PICK,
      S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           window_ff, window_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic [PW-1:0]           ptr_ff, ptr_in;
   logic [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic [SAMPLE_WIDTH-1:0] lo_ff, lo_in;
   logic [SAMPLE_WIDTH-1:0] hi_ff, hi_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH:0]   rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    full;
   logic                    emit;
   logic [CW-1:0]           ptr_next;
   logic [CW-1:0]           window_sat;
   logic [PW-1:0]           hi_idx;
   logic [PW-1:0]           lo_idx;
   logic [PW-1:0]           ring_raddr;
   logic [SAMPLE_WIDTH-1:0] oldest;
   swm_ctrl_type            ctrl;

   logic [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
   swm_flag_type            cell_flag  [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]   cell_live;

   assign req_ready     = (state_ff == S_IDLE);
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_median_x2 = rsp_data_ff;

   // Window holds fill_ff samples; it is full once fill reaches the window size.
   assign full     = (fill_ff == window_ff);
   assign emit     = full || ((fill_ff + CW'(1)) == window_ff);
   assign ptr_next = CW'(ptr_ff) + CW'(1);

   // Clamp the written size into 1..WINDOW_MAX.
   always_comb begin
      if (csr_window_size == '0) begin
         window_sat = CW'(1);
      end else if ({25'd0, csr_window_size} > WINDOW_MAX) begin
         window_sat = CW'(WINDOW_MAX);
      end else begin
         window_sat = CW'(csr_window_size);
      end
   end

   // Middle cells: the same one for an odd window, adjacent pair for an even one.
   assign hi_idx = PW'(window_ff >> 1);
   assign lo_idx = window_ff[0] ? hi_idx : hi_idx - PW'(1);

   // Arrival ring: read the oldest slot at accept, overwrite it at update.
   assign ring_raddr = req_restart ? '0 : ptr_ff;

   swm_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock         (clock),
      .write_enable  (state_ff == S_UPDATE),
      .write_address (ptr_ff),
      .write_data    (sample_ff),
      .read_address  (ring_raddr),
      .read_data     (oldest)
   );

   assign ctrl.update = (state_ff == S_UPDATE);
   assign ctrl.remove = full;

   // Sorted row: each cell compares itself against the leaving and arriving
   // samples and takes its next value from itself, a neighbor or the arriving sample.
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic [SAMPLE_WIDTH-1:0] prev_value;
      logic [SAMPLE_WIDTH-1:0] next_value;
      swm_flag_type            prev_flag;
      swm_flag_type            next_flag;

      assign cell_live[i] = (CW'(i) < fill_ff);

      if (i == 0) begin : g_head
         assign prev_value = '0;
         assign prev_flag  = '0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_flag  = cell_flag[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_tail
         assign next_value = '0;
         assign next_flag  = '0;
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_flag  = cell_flag[i+1];
      end

      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .FIRST        (i == 0)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .in_range   (cell_live[i]),
         .old_value  (oldest),
         .new_value  (sample_ff),
         .prev_value (prev_value),
         .prev_flag  (prev_flag),
         .next_value (next_value),
         .next_flag  (next_flag),
         .value      (cell_value[i]),
         .flag       (cell_flag[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      sample_in    = sample_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               if (req_restart) begin
                  fill_in = '0;
                  ptr_in  = '0;
               end
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // Drop the oldest when full, otherwise grow; advance the ring slot.
            if (!full) begin
               fill_in = fill_ff + CW'(1);
            end
            ptr_in   = (ptr_next == window_ff) ? '0 : PW'(ptr_next);
            state_in = emit ? S_PICK : S_IDLE;
         end
         S_PICK: begin
            lo_in    = cell_value[lo_idx];
            hi_in    = cell_value[hi_idx];
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // Hold here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {lo_ff[SAMPLE_WIDTH-1], lo_ff}
                            + {hi_ff[SAMPLE_WIDTH-1], hi_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A size write empties the window.
      if (csr_write_enable) begin
         window_in = window_sat;
         fill_in   = '0;
         ptr_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= CW'(1);
         fill_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= window_ff)
      else $error("fill count above window size");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(ptr_ff) < window_ff)
      else $error("ring slot outside window");

   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !csr_write_enable) |=> (state_ff == S_UPDATE))
      else $error("accepted transaction did not reach update");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside the emit step");
`endif

endmodule

// ----- rtl/swm_ram.sv -----
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  write_enable,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                      write_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                      read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data <= mem_ff[read_address];
   end

endmodule

// ----- rtl/swm_cell.sv -----
module swm_cell #(
   parameter int SAMPLE_WIDTH = 32,
   parameter bit FIRST        = 1'b0
) (
   input  logic                      clock,
   input  swm_pkg::swm_ctrl_type     ctrl,
   input  logic                      in_range,
   input  logic [SAMPLE_WIDTH-1:0]   old_value,
   input  logic [SAMPLE_WIDTH-1:0]   new_value,
   input  logic [SAMPLE_WIDTH-1:0]   prev_value,
   input  swm_pkg::swm_flag_type     prev_flag,
   input  logic [SAMPLE_WIDTH-1:0]   next_value,
   input  swm_pkg::swm_flag_type     next_flag,
   output logic [SAMPLE_WIDTH-1:0]   value,
   output swm_pkg::swm_flag_type     flag
);

   import swm_pkg::*;

   logic [SAMPLE_WIDTH-1:0] value_ff;
   logic [SAMPLE_WIDTH-1:0] value_in;
   logic [SAMPLE_WIDTH-1:0] self_w;
   logic [SAMPLE_WIDTH-1:0] prev_w;
   logic                    self_w_live;
   logic                    self_w_le;
   logic                    prev_w_le;
   logic                    self_shift;
   logic                    prev_shift;

   assign value          = value_ff;
   assign flag.in_range  = in_range;
   assign flag.below_old = in_range && ($signed(value_ff) < $signed(old_value));
   assign flag.le_new    = $signed(value_ff) <= $signed(new_value);

   // Row after removal: entries at or past the leaving one close up by one.
   assign self_shift  = ctrl.remove && !flag.below_old;
   assign prev_shift  = ctrl.remove && !prev_flag.below_old;
   assign self_w      = self_shift ? next_value : value_ff;
   assign self_w_le   = self_shift ? next_flag.le_new : flag.le_new;
   assign self_w_live = ctrl.remove ? next_flag.in_range : in_range;
   assign prev_w      = prev_shift ? value_ff : prev_value;
   assign prev_w_le   = prev_shift ? flag.le_new : prev_flag.le_new;

   // Insertion: keep, take the new sample, or take the left neighbor.
   always_comb begin
      if (self_w_live && self_w_le) begin
         value_in = self_w;
      end else if (FIRST || prev_w_le) begin
         value_in = new_value;
      end else begin
         value_in = prev_w;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         value_ff <= value_in;
      end
   end

endmodule

// ----- tb/sliding_window_median_top_tb.sv -----
module sliding_window_median_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN_MAX       = 64;
   localparam int SAMPLE_W      = 32;
   localparam int RANDOM_ITEMS  = 950;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 10;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       restart;
   } sample_item_type;

   // DUT ports; the inputs are driven to known values from time zero
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [SAMPLE_W-1:0]             req_sample = '0;
   logic                            req_restart = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [SAMPLE_W:0]               rsp_median_x2;
   logic                            csr_write_enable = 1'b0;
   logic [swm_pkg::CSR_WIDTH-1:0]   csr_window_size = '0;

   // Stimulus and expectation stores
   sample_item_type            sample_q[$];
   logic signed [SAMPLE_W:0]   median_expect_q[$];
   sample_item_type            next_item;

   // Window predictor state
   logic signed [SAMPLE_W-1:0] win_sorted[$];
   logic signed [SAMPLE_W-1:0] win_ring[WIN_MAX];
   int                         ring_ptr;
   int                         win_len;

   // Handshake bookkeeping
   bit  req_taken;
   bit  calm;
   int  send_gap;
   int  stall_left;
   int  hold_left;
   int  hold_asked;
   int  hold_served;

   // Run statistics
   int  errors;
   int  cycle_count;
   int  items_accepted;
   int  restarts_accepted;
   int  medians_checked;
   int  size_writes;
   int  min_size_seen;
   int  max_size_seen;

   sliding_window_median_top #(
      .WINDOW_MAX   (WIN_MAX),
      .SAMPLE_WIDTH (SAMPLE_W)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_x2    (rsp_median_x2),
      .csr_write_enable (csr_write_enable),
      .csr_window_size  (csr_window_size)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Window predictor
   // ---------------------------------------------------------------

   // Clamp a written size into 1..WIN_MAX and empty the window.
   task automatic set_window_len(input logic [swm_pkg::CSR_WIDTH-1:0] value);
      int v;
      v = int'(value);
      if (v == 0) v = 1;
      if (v > WIN_MAX) v = WIN_MAX;
      win_len = v;
      win_sorted.delete();
      ring_ptr = 0;
   endtask

   // Slide one sample into the window; report twice the median once full.
   task automatic median_window_step(input logic signed [SAMPLE_W-1:0] s,
                                     input logic restart,
                                     output bit produced,
                                     output logic signed [SAMPLE_W:0] med);
      int                         pos;
      int                         i;
      int                         k;
      logic signed [SAMPLE_W-1:0] leaving;
      logic signed [SAMPLE_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] hi;
      k = win_len;
      if (restart) begin
         win_sorted.delete();
         ring_ptr = 0;
      end
      if (ring_ptr >= k) ring_ptr = 0;
      if (win_sorted.size() >= k) begin
         // drop one entry equal to the oldest sample, else the top entry
         leaving = win_ring[ring_ptr];
         pos = win_sorted.size() - 1;
         for (i = 0; i < win_sorted.size(); i++) begin
            if (win_sorted[i] == leaving) begin
               pos = i;
               break;
            end
         end
         win_sorted.delete(pos);
         while (win_sorted.size() >= k) void'(win_sorted.pop_back());
      end
      pos = win_sorted.size();
      while (pos > 0 && win_sorted[pos-1] > s) pos--;
      win_sorted.insert(pos, s);
      win_ring[ring_ptr] = s;
      ring_ptr++;
      if (ring_ptr >= k) ring_ptr = 0;
      produced = (win_sorted.size() >= k);
      med = '0;
      if (produced) begin
         if (k % 2) begin
            lo = win_sorted[k/2];
            hi = lo;
         end else begin
            lo = win_sorted[k/2 - 1];
            hi = win_sorted[k/2];
         end
         med = {lo[SAMPLE_W-1], lo} + {hi[SAMPLE_W-1], hi};
      end
   endtask

   // ---------------------------------------------------------------
   // Monitor: sample every handshake at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      bit                       produced;
      logic signed [SAMPLE_W:0] med;
      logic signed [SAMPLE_W:0] want;
      req_taken = req_valid && req_ready && !reset;
      if (reset) begin
         set_window_len(7'd1);
      end else begin
         if (csr_write_enable) set_window_len(csr_window_size);
         // predict from each accepted sample transaction
         if (req_valid && req_ready) begin
            median_window_step($signed(req_sample), req_restart, produced, med);
            items_accepted++;
            if (req_restart) restarts_accepted++;
            if (produced) median_expect_q = {median_expect_q, med};
         end
         // check each accepted result transaction against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (median_expect_q.size() == 0) begin
               $display("%0t: unexpected median result, actual %0d", $time,
                        $signed(rsp_median_x2));
               errors++;
            end else begin
               want = median_expect_q.pop_front();
               medians_checked++;
               if (rsp_median_x2 !== want) begin
                  $display("%0t: median_x2 mismatch, expected %0d, actual %0d", $time,
                           want, $signed(rsp_median_x2));
                  errors++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Request driver: change at the falling edge, hold until accepted
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (sample_q.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
            // start an idle burst of random length
            req_valid <= 1'b0;
            send_gap  <= $urandom_range(0, 16);
         end else if (sample_q.size() > 0) begin
            next_item   = sample_q.pop_front();
            req_valid   <= 1'b1;
            req_sample  <= next_item.sample;
            req_restart <= next_item.restart;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result receiver: random stall bursts plus one long hold-off
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         // hold off long enough for the block to back up into req_ready
         hold_served <= hold_asked;
         hold_left   <= LONG_HOLD - 1;
         rsp_ready   <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("sliding_window_median_top_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s, input logic r);
      sample_item_type it;
      it.sample  = s;
      it.restart = r;
      sample_q = {sample_q, it};
   endtask

   // Wait for all queued samples and results, then let growing-only samples settle.
   task automatic wait_drained();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_valid || median_expect_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the window size while the block is idle.
   task automatic write_window_size(input int unsigned v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_window_size  <= v[swm_pkg::CSR_WIDTH-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      size_writes++;
      if (win_len < min_size_seen) min_size_seen = win_len;
      if (win_len > max_size_seen) max_size_seen = win_len;
   endtask

   // Mix of narrow values (for duplicates), extremes and full-range values.
   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 3) return int'($urandom_range(0, 6)) - 3;
      if (kind == 3) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   initial begin
      int          random_sent;
      int          phase;
      int          n;
      int          i;
      int unsigned size_pick;
      int unsigned restart_odds;
      min_size_seen = WIN_MAX;
      max_size_seen = 1;

      // hold reset, then release it at a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: reset size of one passes each sample through doubled
      queue_sample(32'sh7fff_ffff, 1'b0);
      queue_sample(32'sh8000_0000, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(-1, 1'b0);
      wait_drained();

      // size zero is taken as one; restart on a single-sample window
      write_window_size(0);
      queue_sample(1, 1'b0);
      queue_sample(5, 1'b1);
      wait_drained();

      // even window at both extremes: sum of the two middle entries
      write_window_size(2);
      queue_sample(32'sh7fff_ffff, 1'b0);
      queue_sample(32'sh7fff_ffff, 1'b0);
      queue_sample(32'sh8000_0000, 1'b0);
      queue_sample(32'sh8000_0000, 1'b0);
      wait_drained();

      // odd window with duplicates leaving, then a restart mid-stream
      write_window_size(3);
      queue_sample(5, 1'b0);
      queue_sample(-7, 1'b0);
      queue_sample(5, 1'b0);
      queue_sample(5, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(9, 1'b1);
      queue_sample(1, 1'b0);
      queue_sample(2, 1'b0);
      wait_drained();

      // even window of four
      write_window_size(4);
      queue_sample(10, 1'b0);
      queue_sample(-10, 1'b0);
      queue_sample(3, 1'b0);
      queue_sample(3, 1'b0);
      queue_sample(100, 1'b0);
      wait_drained();

      // Random phases, each with its own window size
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: size_pick = $urandom_range(0, 1);
            1: size_pick = WIN_MAX;
            2: size_pick = $urandom_range(WIN_MAX + 1, 127);
            3: size_pick = $urandom_range(10, WIN_MAX - 1);
            default: size_pick = $urandom_range(2, 9);
         endcase
         if (phase == 0) size_pick = 127;
         if (phase == 1) size_pick = 3;
         write_window_size(size_pick);

         // large windows get several results per phase and few restarts
         if (win_len > 16) begin
            n = win_len * 3;
            restart_odds = 200;
         end else begin
            n = $urandom_range(30, 90);
            restart_odds = 30;
         end
         if (phase == 1) begin
            n = 120;
            hold_asked++;
         end
         if (random_sent >= RANDOM_ITEMS - 170) calm = 1'b1;

         for (i = 0; i < n; i++)
            queue_sample(draw_sample(), $urandom_range(1, restart_odds) == 1);
         random_sent += n;
         phase++;
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d samples (%0d with restart), checked %0d medians.",
               items_accepted, restarts_accepted, medians_checked);
      $display("Window size written %0d times, effective sizes %0d to %0d.",
               size_writes, min_size_seen, max_size_seen);
      if (errors == 0 && median_expect_q.size() == 0) begin
         $display("sliding_window_median_top_tb: PASS");
      end else begin
         if (median_expect_q.size() != 0)
            $display("%0t: %0d expected medians never arrived", $time,
                     median_expect_q.size());
         $display("sliding_window_median_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/swm_pkg.sv
rtl/swm_ram.sv
rtl/swm_cell.sv
rtl/sliding_window_median_top.sv
tb/sliding_window_median_top_tb.sv
